// ----- hw/rtl/bap_pkg.sv -----
// Advertising structure parser package: sizes, element type codes, state
// encodings and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bap_pkg;

  localparam int NAME_CAP   = 29;
  localparam int MAKER_CAP  = 27;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int COMP_W     = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int NAME_AW  = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
  localparam int MAKER_AW = (MAKER_CAP > 1) ? $clog2(MAKER_CAP) : 1;

  localparam logic [BYTE_W-1:0] TYPE_SHORT_NAME = 8'h08;
  localparam logic [BYTE_W-1:0] TYPE_FULL_NAME  = 8'h09;
  localparam logic [BYTE_W-1:0] TYPE_MAKER      = 8'hFF;

  localparam logic [COMP_W-1:0] TRK_COMPANY_RST = 16'h004C;
  localparam logic [BYTE_W-1:0] TRK_TYPE_RST    = 8'h12;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_MAKER   = 2'd2
  } item_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRK_COMPANY = 1'b0,
    REG_TRK_TYPE    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_LEN  = 3'b001,
    PH_TYPE = 3'b010,
    PH_DATA = 3'b100
  } elem_phase_t;

  typedef enum logic [3:0] {
    ST_PARSE = 4'b0001,
    ST_SUM   = 4'b0010,
    ST_NAME  = 4'b0100,
    ST_MAKER = 4'b1000
  } ctrl_state_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  typedef struct packed {
    logic       take_byte;
    logic       load_out;
    item_kind_t kind;
    logic       last;
    idx_op_t    idx_op;
    logic       clear_pkt;
  } bap_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [LEN_W-1:0] name_bytes;
    logic [LEN_W-1:0] maker_len;
    logic [LEN_W-1:0] emit_idx;
  } bap_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bap_if.sv -----
// Channel interfaces of the advertising structure parser: payload byte input
// and result output, each with valid/ready. Depends on bap_pkg.
`default_nettype none

interface bap_in_if;
  import bap_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_packet;
  logic              no_byte;

  modport source(output valid, output data_byte, output end_of_packet, output no_byte,
                 input ready);
  modport sink(input valid, input data_byte, input end_of_packet, input no_byte,
               output ready);
endinterface

interface bap_out_if;
  import bap_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] item_kind;
  logic [LEN_W-1:0]  byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic              name_found;
  logic [LEN_W-1:0]  name_length;
  logic              maker_found;
  logic [COMP_W-1:0] maker_company;
  logic [LEN_W-1:0]  maker_length;
  logic              tracker_flag;
  logic              last_of_run;

  modport source(output valid, output item_kind, output byte_index, output byte_value,
                 output name_found, output name_length, output maker_found,
                 output maker_company, output maker_length, output tracker_flag,
                 output last_of_run, input ready);
  modport sink(input valid, input item_kind, input byte_index, input byte_value,
               input name_found, input name_length, input maker_found,
               input maker_company, input maker_length, input tracker_flag,
               input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bap_dp.sv -----
// Parser datapath: element walk, name double buffer, manufacturer store,
// summary registers, tracker registers and the output register.
// Depends on bap_pkg.
`default_nettype none

module bap_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bap_pkg::bap_cmd_t                  cmd,
  output bap_pkg::bap_status_t               status,
  input  logic [bap_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                               cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bap_pkg::KIND_W-1:0]         out_item_kind,
  output logic [bap_pkg::LEN_W-1:0]          out_byte_index,
  output logic [bap_pkg::BYTE_W-1:0]         out_byte_value,
  output logic                               out_name_found,
  output logic [bap_pkg::LEN_W-1:0]          out_name_length,
  output logic                               out_maker_found,
  output logic [bap_pkg::COMP_W-1:0]         out_maker_company,
  output logic [bap_pkg::LEN_W-1:0]          out_maker_length,
  output logic                               out_tracker_flag,
  output logic                               out_last_of_run
);
  import bap_pkg::*;

  elem_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic              stopped_r, stopped_nxt;
  logic              nfound_r, nfound_nxt;
  logic [LEN_W-1:0]  nlen_r, nlen_nxt;
  logic              mfound_r, mfound_nxt;
  logic [LEN_W-1:0]  mlen_r, mlen_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic [BYTE_W-1:0] maker0_r, maker0_nxt;
  logic              store_sel_r, store_sel_nxt;
  logic [LEN_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic [COMP_W-1:0] trk_company_r, trk_company_nxt;
  logic [BYTE_W-1:0] trk_type_r, trk_type_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0] kind_r;
  logic [LEN_W-1:0]  bidx_r;
  logic [BYTE_W-1:0] bval_r;
  logic              onf_r, omf_r, otrk_r, olast_r;
  logic [LEN_W-1:0]  onlen_r, omlen_r;
  logic [COMP_W-1:0] ocomp_r;

  // name_a/name_b: committed name in one bank, replacing name built in the other
  logic [BYTE_W-1:0] name_a_mem  [NAME_CAP];
  logic [BYTE_W-1:0] name_b_mem  [NAME_CAP];
  logic [BYTE_W-1:0] maker_mem   [MAKER_CAP];

  logic              walk, at_type, at_data, commit;
  logic              name_cand, maker_cand, name_wr, maker_wr, maker_data;
  logic [BYTE_W-1:0] type_cur, pos_inc, mk_off, name_n_full, maker_n_full;
  logic [LEN_W-1:0]  name_n, maker_n;
  logic              tracker;
  logic              out_free;

  assign walk     = cmd.take_byte && !stopped_r;
  assign at_type  = walk && (phase_r == PH_TYPE);
  assign at_data  = walk && (phase_r == PH_DATA);
  assign type_cur = (phase_r == PH_TYPE) ? in_data_byte : type_r;

  assign name_cand  = (type_cur == TYPE_FULL_NAME) ||
                      ((type_cur == TYPE_SHORT_NAME) && !nfound_r);
  assign maker_cand = (type_cur == TYPE_MAKER) && (len_r >= 8'd3) && !mfound_r;

  assign pos_inc = pos_r + 8'd1;
  assign mk_off  = pos_r - 8'd2;
  assign commit  = (at_type && (len_r == 8'd1)) ||
                   (at_data && (pos_inc == (len_r - 8'd1)));

  assign name_n_full  = len_r - 8'd1;
  assign maker_n_full = len_r - 8'd3;
  assign name_n  = (name_n_full > BYTE_W'(NAME_CAP)) ? LEN_W'(NAME_CAP)
                                                     : name_n_full[LEN_W-1:0];
  assign maker_n = (maker_n_full > BYTE_W'(MAKER_CAP)) ? LEN_W'(MAKER_CAP)
                                                       : maker_n_full[LEN_W-1:0];

  assign name_wr    = at_data && name_cand && (pos_r < BYTE_W'(NAME_CAP));
  assign maker_data = at_data && !name_cand && maker_cand;
  assign maker_wr   = maker_data && (pos_r >= 8'd2) && (mk_off < BYTE_W'(MAKER_CAP));

  always_comb begin
    phase_nxt       = phase_r;
    len_nxt         = len_r;
    type_nxt        = type_r;
    pos_nxt         = pos_r;
    stopped_nxt     = stopped_r;
    nfound_nxt      = nfound_r;
    nlen_nxt        = nlen_r;
    mfound_nxt      = mfound_r;
    mlen_nxt        = mlen_r;
    comp_nxt        = comp_r;
    maker0_nxt      = maker0_r;
    store_sel_nxt   = store_sel_r;
    trk_company_nxt = trk_company_r;
    trk_type_nxt    = trk_type_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TRK_COMPANY: trk_company_nxt = cfg_wdata[COMP_W-1:0];
        REG_TRK_TYPE:    trk_type_nxt    = cfg_wdata[BYTE_W-1:0];
        default:         trk_type_nxt    = trk_type_r;
      endcase
    end

    if (cmd.clear_pkt) begin
      phase_nxt   = PH_LEN;
      len_nxt     = '0;
      type_nxt    = '0;
      pos_nxt     = '0;
      stopped_nxt = 1'b0;
      nfound_nxt  = 1'b0;
      nlen_nxt    = '0;
      mfound_nxt  = 1'b0;
      mlen_nxt    = '0;
      comp_nxt    = '0;
    end else if (walk) begin
      unique case (phase_r)
        PH_LEN: begin
          if (in_data_byte == '0) begin
            stopped_nxt = 1'b1;
          end else begin
            len_nxt   = in_data_byte;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt  = in_data_byte;
          pos_nxt   = '0;
          phase_nxt = (len_r == 8'd1) ? PH_LEN : PH_DATA;
        end
        PH_DATA: begin
          pos_nxt = pos_inc;
          if (commit) begin
            phase_nxt = PH_LEN;
          end
          if (maker_data && (pos_r == 8'd0)) begin
            comp_nxt[7:0] = in_data_byte;
          end
          if (maker_data && (pos_r == 8'd1)) begin
            comp_nxt[15:8] = in_data_byte;
          end
          if (maker_wr && (pos_r == 8'd2)) begin
            maker0_nxt = in_data_byte;
          end
        end
        default: phase_nxt = PH_LEN;
      endcase

      if (commit) begin
        if (name_cand) begin
          nfound_nxt    = 1'b1;
          nlen_nxt      = name_n;
          store_sel_nxt = !store_sel_r;
        end else if (maker_cand) begin
          mfound_nxt = 1'b1;
          mlen_nxt   = maker_n;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD: emit_idx_nxt = emit_idx_r;
      IDX_CLR:  emit_idx_nxt = '0;
      IDX_INC:  emit_idx_nxt = emit_idx_r + LEN_W'(1);
      default:  emit_idx_nxt = emit_idx_r;
    endcase
  end

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEN;
      len_r         <= '0;
      type_r        <= '0;
      pos_r         <= '0;
      stopped_r     <= 1'b0;
      nfound_r      <= 1'b0;
      nlen_r        <= '0;
      mfound_r      <= 1'b0;
      mlen_r        <= '0;
      comp_r        <= '0;
      store_sel_r   <= 1'b0;
      emit_idx_r    <= '0;
      trk_company_r <= TRK_COMPANY_RST;
      trk_type_r    <= TRK_TYPE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      len_r         <= len_nxt;
      type_r        <= type_nxt;
      pos_r         <= pos_nxt;
      stopped_r     <= stopped_nxt;
      nfound_r      <= nfound_nxt;
      nlen_r        <= nlen_nxt;
      mfound_r      <= mfound_nxt;
      mlen_r        <= mlen_nxt;
      comp_r        <= comp_nxt;
      store_sel_r   <= store_sel_nxt;
      emit_idx_r    <= emit_idx_nxt;
      trk_company_r <= trk_company_nxt;
      trk_type_r    <= trk_type_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    maker0_r <= maker0_nxt;
  end

  // store_sel_r low: bank a holds the committed name, bank b takes new bytes
  always_ff @(posedge clk) begin
    if (name_wr && !store_sel_r) begin
      name_b_mem[pos_r[NAME_AW-1:0]] <= in_data_byte;
    end
    if (name_wr && store_sel_r) begin
      name_a_mem[pos_r[NAME_AW-1:0]] <= in_data_byte;
    end
    if (maker_wr) begin
      maker_mem[mk_off[MAKER_AW-1:0]] <= in_data_byte;
    end
  end

  assign tracker = mfound_r && (comp_r == trk_company_r) && (mlen_r != '0) &&
                   (maker0_r == trk_type_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind_r  <= cmd.kind;
      olast_r <= cmd.last;
      unique case (cmd.kind)
        KIND_SUMMARY: begin
          bidx_r  <= '0;
          bval_r  <= '0;
          onf_r   <= nfound_r;
          onlen_r <= nlen_r;
          omf_r   <= mfound_r;
          ocomp_r <= mfound_r ? comp_r : '0;
          omlen_r <= mlen_r;
          otrk_r  <= tracker;
        end
        KIND_NAME, KIND_MAKER: begin
          bidx_r  <= emit_idx_r;
          if (cmd.kind == KIND_NAME) begin
            bval_r <= store_sel_r ? name_b_mem[emit_idx_r[NAME_AW-1:0]]
                                  : name_a_mem[emit_idx_r[NAME_AW-1:0]];
          end else begin
            bval_r <= maker_mem[emit_idx_r[MAKER_AW-1:0]];
          end
          onf_r   <= 1'b0;
          onlen_r <= '0;
          omf_r   <= 1'b0;
          ocomp_r <= '0;
          omlen_r <= '0;
          otrk_r  <= 1'b0;
        end
        default: begin
          bidx_r  <= '0;
          bval_r  <= '0;
          onf_r   <= 1'b0;
          onlen_r <= '0;
          omf_r   <= 1'b0;
          ocomp_r <= '0;
          omlen_r <= '0;
          otrk_r  <= 1'b0;
        end
      endcase
    end
  end

  assign status.out_free   = out_free;
  assign status.name_bytes = nlen_r;
  assign status.maker_len  = mlen_r;
  assign status.emit_idx   = emit_idx_r;

  assign out_valid         = out_valid_r;
  assign out_item_kind     = kind_r;
  assign out_byte_index    = bidx_r;
  assign out_byte_value    = bval_r;
  assign out_name_found    = onf_r;
  assign out_name_length   = onlen_r;
  assign out_maker_found   = omf_r;
  assign out_maker_company = ocomp_r;
  assign out_maker_length  = omlen_r;
  assign out_tracker_flag  = otrk_r;
  assign out_last_of_run   = olast_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bap_ctrl.sv -----
// Parser controller: accepts payload transactions, then sequences the
// summary, name and manufacturer result burst. Depends on bap_pkg.
`default_nettype none

module bap_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_end_of_packet,
  input  logic                 in_no_byte,
  output logic                 in_ready,
  input  bap_pkg::bap_status_t status,
  output bap_pkg::bap_cmd_t    cmd
);
  import bap_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic             accept;
  logic             name_end, maker_end;
  logic [LEN_W-1:0] name_last_idx, maker_last_idx;

  assign in_ready       = (state_r == ST_PARSE);
  assign accept         = in_valid && in_ready;
  assign name_last_idx  = status.name_bytes - LEN_W'(1);
  assign maker_last_idx = status.maker_len - LEN_W'(1);
  assign name_end       = (status.emit_idx == name_last_idx);
  assign maker_end      = (status.emit_idx == maker_last_idx);

  always_comb begin
    state_nxt = state_r;
    cmd       = '{take_byte: 1'b0, load_out: 1'b0, kind: KIND_SUMMARY, last: 1'b0,
                  idx_op: IDX_HOLD, clear_pkt: 1'b0};

    unique case (state_r)
      ST_PARSE: begin
        cmd.take_byte = accept && !in_no_byte;
        if (accept && in_end_of_packet) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.kind     = KIND_SUMMARY;
          cmd.idx_op   = IDX_CLR;
          priority if (status.name_bytes != '0) begin
            state_nxt = ST_NAME;
          end else if (status.maker_len != '0) begin
            state_nxt = ST_MAKER;
          end else begin
            cmd.last      = 1'b1;
            cmd.clear_pkt = 1'b1;
            state_nxt     = ST_PARSE;
          end
        end
      end
      ST_NAME: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.kind     = KIND_NAME;
          if (name_end) begin
            cmd.idx_op = IDX_CLR;
            if (status.maker_len != '0) begin
              state_nxt = ST_MAKER;
            end else begin
              cmd.last      = 1'b1;
              cmd.clear_pkt = 1'b1;
              state_nxt     = ST_PARSE;
            end
          end else begin
            cmd.idx_op = IDX_INC;
          end
        end
      end
      ST_MAKER: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.kind     = KIND_MAKER;
          if (maker_end) begin
            cmd.idx_op    = IDX_CLR;
            cmd.last      = 1'b1;
            cmd.clear_pkt = 1'b1;
            state_nxt     = ST_PARSE;
          end else begin
            cmd.idx_op = IDX_INC;
          end
        end
      end
      default: state_nxt = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PARSE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ble_adv_structure_parser_top.sv -----
// Top level of the advertising structure parser: controller, datapath and
// channel wiring. Depends on bap_pkg, bap_if, bap_ctrl and bap_dp.
//
//   channel  | dir | handshake     | carries
//   in_ch    | in  | valid/ready   | data_byte, end_of_packet, no_byte
//   out_ch   | out | valid/ready   | summary, name byte or payload byte
//   cfg_*    | in  | cfg_we only   | tracker company id / type byte
//
// Payload transactions are taken one per cycle while parsing.
// After the end-of-packet transaction, input ready stays low while the burst
// of 1 + name_length + maker_length results goes out, one per cycle as the
// output register drains. out_ch stalls hold the burst; the input reopens
// while the last result still waits. Synchronous active-low reset.
`default_nettype none

module ble_adv_structure_parser_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bap_in_if.sink                         in_ch,
  bap_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bap_pkg::*;

  bap_cmd_t    cmd;
  bap_status_t status;

  bap_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_end_of_packet(in_ch.end_of_packet),
    .in_no_byte      (in_ch.no_byte),
    .in_ready        (in_ch.ready),
    .status          (status),
    .cmd             (cmd)
  );

  bap_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_data_byte     (in_ch.data_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_item_kind    (out_ch.item_kind),
    .out_byte_index   (out_ch.byte_index),
    .out_byte_value   (out_ch.byte_value),
    .out_name_found   (out_ch.name_found),
    .out_name_length  (out_ch.name_length),
    .out_maker_found  (out_ch.maker_found),
    .out_maker_company(out_ch.maker_company),
    .out_maker_length (out_ch.maker_length),
    .out_tracker_flag (out_ch.tracker_flag),
    .out_last_of_run  (out_ch.last_of_run)
  );

  a_eop_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.end_of_packet |=> !in_ch.ready)
    else $error("input still open after end of packet");

  a_lone_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.item_kind == KIND_SUMMARY) && out_ch.last_of_run
      |-> (out_ch.name_length == '0) && (out_ch.maker_length == '0))
    else $error("summary marked last while bytes are pending");

  a_name_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.item_kind == KIND_NAME)
      |-> (out_ch.byte_index < LEN_W'(NAME_CAP)))
    else $error("name byte index beyond capacity");

  a_maker_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.item_kind == KIND_MAKER)
      |-> (out_ch.byte_index < LEN_W'(MAKER_CAP)))
    else $error("payload byte index beyond capacity");

endmodule

`default_nettype wire

// ----- dv/tb_ble_adv_structure_parser_top.sv -----
// Testbench for ble_adv_structure_parser_top: directed and random advertising packets,
// random idle and stall on both channels, every result checked against a local parser
// or the directed table. Depends on bap_pkg, bap_if and the RTL of the parser.
module tb_ble_adv_structure_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bap_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DIR_ROWS      = 27;

  typedef struct packed {
    logic              name_found;
    logic [LEN_W-1:0]  name_length;
    logic              maker_found;
    logic [COMP_W-1:0] maker_company;
    logic [LEN_W-1:0]  maker_length;
    logic              tracker_flag;
  } adv_summary_t;

  typedef struct packed {
    item_kind_t        item_kind;
    logic [LEN_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    adv_summary_t      sum;
    logic              last_of_run;
  } adv_result_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         end_of_packet;
    logic         no_byte;
    logic         typed;
    adv_summary_t sum;
  } dir_row_t;

  localparam adv_summary_t SUM_NONE = '0;

  dir_row_t dir_table [DIR_ROWS] = '{
    // empty packet
    '{8'h00, 1'b1, 1'b1, 1'b1, SUM_NONE},
    // tracker at reset registers
    '{8'h04, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h4C, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h12, 1'b1, 1'b0, 1'b1, '{1'b0, 5'd0, 1'b1, 16'h004C, 5'd1, 1'b1}},
    // length-one complete name: empty name
    '{8'h01, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h09, 1'b1, 1'b0, 1'b1, '{1'b1, 5'd0, 1'b0, 16'h0000, 5'd0, 1'b0}},
    // short name replaced by complete name, end marker without byte
    '{8'h02, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h08, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h41, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h03, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h09, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h42, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h43, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h00, 1'b1, 1'b1, 1'b0, SUM_NONE},
    // zero length halts the walk; filler without byte
    '{8'h00, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'hAA, 1'b0, 1'b1, 1'b0, SUM_NONE},
    '{8'h05, 1'b1, 1'b0, 1'b1, SUM_NONE},
    // complete name cut by packet end
    '{8'h04, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h09, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h61, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h62, 1'b1, 1'b0, 1'b1, SUM_NONE},
    // maker element with company only
    '{8'h03, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h34, 1'b0, 1'b0, 1'b0, SUM_NONE},
    '{8'h12, 1'b1, 1'b0, 1'b1, '{1'b0, 5'd0, 1'b1, 16'h1234, 5'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bap_in_if  in_ch ();
  bap_out_if out_ch ();

  ble_adv_structure_parser_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // parser state mirror
  elem_phase_t ph;
  logic [7:0] el_len, el_type, el_pos;
  logic walk_halted;
  logic [7:0] name_buf [NAME_CAP];
  logic [7:0] name_tmp [NAME_CAP];
  logic [7:0] maker_buf [MAKER_CAP];
  logic got_name, got_maker;
  logic [LEN_W-1:0] name_cnt, maker_cnt;
  logic [15:0] company_acc;
  logic [15:0] trk_company;
  logic [7:0] trk_type;

  adv_result_t results_due [$];
  logic [7:0] pkt_bytes [$];

  logic row_typed;
  adv_summary_t row_sum;
  logic calm;

  int errors, items_sent, results_seen, packets_seen;
  int tracker_hits, names_full, makers_full;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic name_cand();
    return el_type == TYPE_FULL_NAME || (el_type == TYPE_SHORT_NAME && !got_name);
  endfunction

  function automatic logic maker_cand();
    return el_type == TYPE_MAKER && el_len >= 8'd3 && !got_maker;
  endfunction

  function automatic void close_element();
    int n;
    int i;
    if (name_cand()) begin
      n = int'(el_len) - 1;
      if (n > NAME_CAP) n = NAME_CAP;
      for (i = 0; i < n; i++) name_buf[i] = name_tmp[i];
      got_name = 1'b1;
      name_cnt = LEN_W'(n);
    end else if (maker_cand()) begin
      n = int'(el_len) - 3;
      if (n > MAKER_CAP) n = MAKER_CAP;
      got_maker = 1'b1;
      maker_cnt = LEN_W'(n);
    end
  endfunction

  function automatic void walk_byte(logic [7:0] b);
    int p;
    if (walk_halted) return;
    case (ph)
      PH_LEN: begin
        if (b == 8'h00) begin
          walk_halted = 1'b1;
        end else begin
          el_len = b;
          ph = PH_TYPE;
        end
      end
      PH_TYPE: begin
        el_type = b;
        el_pos = 8'd0;
        if (el_len == 8'd1) begin
          close_element();
          ph = PH_LEN;
        end else begin
          ph = PH_DATA;
        end
      end
      default: begin
        p = int'(el_pos);
        if (name_cand()) begin
          if (p < NAME_CAP) name_tmp[p] = b;
        end else if (maker_cand()) begin
          if (p == 0) company_acc[7:0] = b;
          else if (p == 1) company_acc[15:8] = b;
          else if (p - 2 < MAKER_CAP) maker_buf[p-2] = b;
        end
        el_pos = el_pos + 8'd1;
        if (int'(el_pos) == int'(el_len) - 1) begin
          close_element();
          ph = PH_LEN;
        end
      end
    endcase
  endfunction

  function automatic void clear_walk();
    ph = PH_LEN;
    el_len = 8'd0;
    el_type = 8'd0;
    el_pos = 8'd0;
    walk_halted = 1'b0;
    got_name = 1'b0;
    got_maker = 1'b0;
    name_cnt = '0;
    maker_cnt = '0;
    company_acc = 16'h0000;
  endfunction

  // one accepted input transaction; an end of packet queues the whole burst
  function automatic void predict_packet_results(logic [7:0] b, logic eop, logic nob);
    adv_result_t r;
    adv_summary_t s;
    int i, nl, ml;
    if (!nob) walk_byte(b);
    if (!eop) return;
    s = '0;
    s.name_found = got_name;
    s.name_length = got_name ? name_cnt : '0;
    s.maker_found = got_maker;
    s.maker_length = got_maker ? maker_cnt : '0;
    s.maker_company = got_maker ? company_acc : 16'h0000;
    s.tracker_flag = got_maker && company_acc == trk_company && s.maker_length != '0 &&
                     maker_buf[0] == trk_type;
    nl = int'(s.name_length);
    ml = int'(s.maker_length);
    packets_seen++;
    if (s.tracker_flag) tracker_hits++;
    if (nl == NAME_CAP) names_full++;
    if (ml == MAKER_CAP) makers_full++;
    r = '0;
    r.item_kind = KIND_SUMMARY;
    r.sum = row_typed ? row_sum : s;
    r.last_of_run = (nl == 0 && ml == 0);
    results_due.push_back(r);
    for (i = 0; i < nl; i++) begin
      r = '0;
      r.item_kind = KIND_NAME;
      r.byte_index = LEN_W'(i);
      r.byte_value = name_buf[i];
      r.last_of_run = (i == nl - 1 && ml == 0);
      results_due.push_back(r);
    end
    for (i = 0; i < ml; i++) begin
      r = '0;
      r.item_kind = KIND_MAKER;
      r.byte_index = LEN_W'(i);
      r.byte_value = maker_buf[i];
      r.last_of_run = (i == ml - 1);
      results_due.push_back(r);
    end
    clear_walk();
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(string fname, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, fname, got, want));
    end
  endtask

  task automatic check_result();
    adv_result_t want;
    results_seen++;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      return;
    end
    want = results_due.pop_front();
    check_field("item_kind", 16'(out_ch.item_kind), 16'(want.item_kind));
    check_field("byte_index", 16'(out_ch.byte_index), 16'(want.byte_index));
    check_field("byte_value", 16'(out_ch.byte_value), 16'(want.byte_value));
    check_field("name_found", 16'(out_ch.name_found), 16'(want.sum.name_found));
    check_field("name_length", 16'(out_ch.name_length), 16'(want.sum.name_length));
    check_field("maker_found", 16'(out_ch.maker_found), 16'(want.sum.maker_found));
    check_field("maker_company", out_ch.maker_company, want.sum.maker_company);
    check_field("maker_length", 16'(out_ch.maker_length), 16'(want.sum.maker_length));
    check_field("tracker_flag", 16'(out_ch.tracker_flag), 16'(want.sum.tracker_flag));
    check_field("last_of_run", 16'(out_ch.last_of_run), 16'(want.last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_packet_results(in_ch.data_byte, in_ch.end_of_packet, in_ch.no_byte);
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else begin
        out_ch.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_idle();
      end
    end
  end

  task automatic drive_item(logic [7:0] b, logic eop, logic nob, logic typed,
                            adv_summary_t sum);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.end_of_packet = eop;
    in_ch.no_byte = nob;
    row_typed = typed;
    row_sum = sum;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (!nob || eop) items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_tracker(logic [15:0] company, logic [7:0] type_byte);
    cfg_we = 1'b1;
    cfg_index = REG_TRK_COMPANY;
    cfg_wdata = company;
    @(posedge clk);
    trk_company = company;
    @(negedge clk);
    cfg_index = REG_TRK_TYPE;
    cfg_wdata = {8'h00, type_byte};
    @(posedge clk);
    trk_type = type_byte;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 3))
      0: return TYPE_FULL_NAME;
      1: return TYPE_SHORT_NAME;
      2: return TYPE_MAKER;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_element();
    int sel, dlen, i;
    logic [7:0] ty, b;
    logic hit_co, hit_ty;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      pkt_bytes.push_back(8'h00);
      return;
    end
    if (sel < 14) begin
      pkt_bytes.push_back(8'h01);
      pkt_bytes.push_back(pick_type());
      return;
    end
    dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 36) : $urandom_range(0, 7);
    if (sel < 35) ty = TYPE_FULL_NAME;
    else if (sel < 55) ty = TYPE_SHORT_NAME;
    else if (sel < 82) ty = TYPE_MAKER;
    else ty = 8'($urandom);
    if (ty == TYPE_MAKER && dlen < 2 && $urandom_range(0, 3) != 0) dlen = dlen + 2;
    hit_co = 1'($urandom_range(0, 1));
    hit_ty = 1'($urandom_range(0, 1));
    pkt_bytes.push_back(8'(dlen + 1));
    pkt_bytes.push_back(ty);
    for (i = 0; i < dlen; i++) begin
      b = 8'($urandom);
      if (ty == TYPE_MAKER && hit_co && i == 0) b = trk_company[7:0];
      if (ty == TYPE_MAKER && hit_co && i == 1) b = trk_company[15:8];
      if (ty == TYPE_MAKER && hit_ty && i == 2) b = trk_type;
      pkt_bytes.push_back(b);
    end
  endfunction

  function automatic void build_packet();
    int sel, n, i, cut;
    pkt_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 4) return;
    if (sel < 10) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom));
      return;
    end
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) add_element();
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(2, 40);
      pkt_bytes.push_back(8'(cut));
      if ($urandom_range(0, 3) != 0) begin
        pkt_bytes.push_back(pick_type());
        n = $urandom_range(0, cut - 2);
        for (i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom));
      end
    end
  endfunction

  task automatic send_packet();
    int i;
    logic tail_on_byte;
    tail_on_byte = (pkt_bytes.size() != 0) && ($urandom_range(0, 2) != 0);
    for (i = 0; i < pkt_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) drive_item(8'($urandom), 1'b0, 1'b1, 1'b0, SUM_NONE);
      drive_item(pkt_bytes[i], tail_on_byte && i == pkt_bytes.size() - 1, 1'b0, 1'b0,
                 SUM_NONE);
    end
    if (!tail_on_byte) drive_item(8'($urandom), 1'b1, 1'b1, 1'b0, SUM_NONE);
  endtask

  initial begin
    #40_000_000;
    $display("ble_adv_structure_parser_top test failed");
    $finish;
  end

  initial begin
    int r, phase_i, goal;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_packet = 1'b0;
    in_ch.no_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TRK_COMPANY;
    cfg_wdata = '0;
    row_typed = 1'b0;
    row_sum = SUM_NONE;
    calm = 1'b0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    packets_seen = 0;
    tracker_hits = 0;
    names_full = 0;
    makers_full = 0;
    for (r = 0; r < NAME_CAP; r++) begin
      name_buf[r] = 8'h00;
      name_tmp[r] = 8'h00;
    end
    for (r = 0; r < MAKER_CAP; r++) maker_buf[r] = 8'h00;
    trk_company = TRK_COMPANY_RST;
    trk_type = TRK_TYPE_RST;
    clear_walk();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      drive_item(dir_table[r].data_byte, dir_table[r].end_of_packet, dir_table[r].no_byte,
                 dir_table[r].typed, dir_table[r].sum);
    end

    for (phase_i = 0; phase_i < 4; phase_i++) begin
      drain_results();
      case (phase_i)
        0: load_tracker(16'($urandom), 8'($urandom));
        1: load_tracker(16'h0000, 8'h00);
        2: load_tracker(16'hFFFF, 8'hFF);
        default: load_tracker(TRK_COMPANY_RST, TRK_TYPE_RST);
      endcase
      goal = items_sent + 70;
      while (items_sent < goal) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0) drain_results();
        build_packet();
        send_packet();
      end
    end

    calm = 1'b0;
    in_ch.valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("Ran %0d packets over %0d input transactions and 4 tracker settings; %0d results.",
             packets_seen, items_sent, results_seen);
    $display("Tracker summaries: %0d, full-capacity names: %0d, full-capacity payloads: %0d.",
             tracker_hits, names_full, makers_full);
    if (errors == 0) begin
      $display("ble_adv_structure_parser_top test passed");
    end else begin
      $display("ble_adv_structure_parser_top test failed");
    end
    $finish;
  end

endmodule
